[rtl/core/cpu_alu_and_bit_ops_flags_core_macros.svh]
// ----------------------------------------------------------------------------
// cpu_alu_and_bit_ops_flags_core_macros.svh
// Assertion helpers for the ALU core, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_AND_BIT_OPS_FLAGS_CORE_MACROS_SVH
`define CPU_ALU_AND_BIT_OPS_FLAGS_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define CABF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked after the antecedent, once past the input and result registers (accept to strobe)
`define CABF_ASSERT_DLY2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[rtl/core/cabf_pkg.sv]
// ----------------------------------------------------------------------------
// cabf_pkg
// Beat types, opcodes and flag positions for the 8/16-bit ALU core.
// ----------------------------------------------------------------------------
package cabf_pkg;

  // Opcodes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_ADC   = 5'd1;
  localparam logic [4:0] OP_SUB   = 5'd2;
  localparam logic [4:0] OP_SBC   = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_XOR   = 5'd5;
  localparam logic [4:0] OP_OR    = 5'd6;
  localparam logic [4:0] OP_CP    = 5'd7;
  localparam logic [4:0] OP_INC   = 5'd8;
  localparam logic [4:0] OP_DEC   = 5'd9;
  localparam logic [4:0] OP_RLC   = 5'd10;
  localparam logic [4:0] OP_RRC   = 5'd11;
  localparam logic [4:0] OP_RL    = 5'd12;
  localparam logic [4:0] OP_RR    = 5'd13;
  localparam logic [4:0] OP_SLA   = 5'd14;
  localparam logic [4:0] OP_SRA   = 5'd15;
  localparam logic [4:0] OP_SWAP  = 5'd16;
  localparam logic [4:0] OP_SRL   = 5'd17;
  localparam logic [4:0] OP_BIT   = 5'd18;
  localparam logic [4:0] OP_RES   = 5'd19;
  localparam logic [4:0] OP_SET   = 5'd20;
  localparam logic [4:0] OP_ADD16 = 5'd21;

  // Flag bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } cabf_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } cabf_out_t;

endpackage

[rtl/core/cabf_alu.sv]
// ----------------------------------------------------------------------------
// cabf_alu
// Combinational datapath: arithmetic, logic, shifts, bit ops and flags.
// ----------------------------------------------------------------------------
module cabf_alu (
  input  cabf_pkg::cabf_in_t  in_beat,
  output cabf_pkg::cabf_out_t out_beat
);
  import cabf_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        t;
  logic [8:0]  add9;
  logic [4:0]  addh;
  logic [8:0]  sub9;
  logic [4:0]  subh;
  logic [16:0] add17;
  logic [12:0] add13;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  mask8;

  assign a     = in_beat.operand_a[7:0];
  assign b     = in_beat.operand_b[7:0];
  assign cin   = in_beat.flags_in[FLAG_C];
  // carry/borrow in only for adc and sbc
  assign t     = cin & ((in_beat.opcode == OP_ADC) | (in_beat.opcode == OP_SBC));

  // 8-bit adder and subtractor with nibble carries
  assign add9  = {1'b0, a} + {1'b0, b} + {8'h00, t};
  assign addh  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
  assign sub9  = {1'b0, a} - {1'b0, b} - {8'h00, t};
  assign subh  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
  assign inc8  = a + 8'h01;
  assign dec8  = a - 8'h01;

  // 16-bit add, half carry out of bit 11
  assign add17 = {1'b0, in_beat.operand_a} + {1'b0, in_beat.operand_b};
  assign add13 = {1'b0, in_beat.operand_a[11:0]} + {1'b0, in_beat.operand_b[11:0]};

  assign mask8 = 8'h01 << in_beat.bit_index;

  // Result and flag select
  always_comb begin
    logic [7:0] r8;
    logic       z;
    logic       n;
    logic       h;
    logic       c;
    logic       use8;
    r8   = 8'h00;
    z    = in_beat.flags_in[FLAG_Z];
    n    = in_beat.flags_in[FLAG_N];
    h    = in_beat.flags_in[FLAG_H];
    c    = cin;
    use8 = 1'b1;
    out_beat.result = in_beat.operand_a;
    case (in_beat.opcode)
      OP_ADD, OP_ADC: begin
        r8 = add9[7:0]; n = 1'b0; h = addh[4]; c = add9[8];
      end
      OP_SUB, OP_SBC: begin
        r8 = sub9[7:0]; n = 1'b1; h = subh[4]; c = sub9[8];
      end
      OP_CP: begin
        r8 = sub9[7:0]; n = 1'b1; h = subh[4]; c = sub9[8]; use8 = 1'b0;
      end
      OP_AND: begin
        r8 = a & b; n = 1'b0; h = 1'b1; c = 1'b0;
      end
      OP_XOR: begin
        r8 = a ^ b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_OR: begin
        r8 = a | b; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_INC: begin
        r8 = inc8; n = 1'b0; h = (a[3:0] == 4'hF);
      end
      OP_DEC: begin
        r8 = dec8; n = 1'b1; h = (a[3:0] == 4'h0);
      end
      OP_RLC: begin
        r8 = {a[6:0], a[7]}; n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RRC: begin
        r8 = {a[0], a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_RL: begin
        r8 = {a[6:0], cin}; n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_RR: begin
        r8 = {cin, a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0}; n = 1'b0; h = 1'b0; c = a[7];
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]}; n = 1'b0; h = 1'b0; c = 1'b0;
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]}; n = 1'b0; h = 1'b0; c = a[0];
      end
      OP_BIT: begin
        // Z is the inverse of the tested bit, value passes through
        use8 = 1'b0;
        z    = ~a[in_beat.bit_index];
        n    = 1'b0;
        h    = 1'b1;
      end
      OP_RES: begin
        r8 = a & ~mask8;
      end
      OP_SET: begin
        r8 = a | mask8;
      end
      OP_ADD16: begin
        use8 = 1'b0;
        out_beat.result = add17[15:0];
        n = 1'b0; h = add13[12]; c = add17[16];
      end
      default: begin
        // unused codes pass value and flags through
        use8 = 1'b0;
      end
    endcase
    // Z from the 8-bit result where the op defines it
    if (use8) begin
      out_beat.result = {8'h00, r8};
      if ((in_beat.opcode != OP_RES) && (in_beat.opcode != OP_SET)) begin
        z = (r8 == 8'h00);
      end
    end else if (in_beat.opcode == OP_CP) begin
      z = (r8 == 8'h00);
    end
    out_beat.flags_out = {z, n, h, c};
  end

endmodule

[rtl/core/cpu_alu_and_bit_ops_flags_core.sv]
// Path: an accepted beat is captured in the input register, then its ALU result in
// the result register, which drives out_data with out_valid high.
// Throughput: one beat per cycle; busy stays low, there is no stall path
// since the receiver takes every strobed result.
// Reset: synchronous, active low; clears both valid stages, payload is not reset.
// ----------------------------------------------------------------------------
// cpu_alu_and_bit_ops_flags_core
// Top level: input register, ALU datapath, result register and strobe.
// ----------------------------------------------------------------------------
`include "cpu_alu_and_bit_ops_flags_core_macros.svh"

module cpu_alu_and_bit_ops_flags_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cabf_pkg::cabf_in_t  in_data,
  output logic                out_valid,
  output cabf_pkg::cabf_out_t out_data
);
  import cabf_pkg::*;

  logic      accept;
  logic      in_vld_r;
  cabf_in_t  in_beat_r;
  cabf_out_t alu_beat;
  logic      out_vld_r;
  cabf_out_t out_beat_r;

  // No multi-cycle work: always ready for a beat
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_beat_r <= in_data;
    end
  end

  cabf_alu u_alu (
    .in_beat  (in_beat_r),
    .out_beat (alu_beat)
  );

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_beat_r <= alu_beat;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  // Checks
  `CABF_ASSERT_DLY2(a_strobe_follows, accept, out_valid, "accepted beat gave no strobe")
  `CABF_ASSERT_DLY2(a_cp_keeps_a, accept && (in_data.opcode == OP_CP),
    out_data.result == $past(in_data.operand_a, 2), "cp changed the value")
  `CABF_ASSERT_DLY2(a_byte_ops_zero_high,
    accept && (in_data.opcode <= OP_SET) && (in_data.opcode != OP_CP) &&
    (in_data.opcode != OP_BIT), out_data.result[15:8] == 8'h00,
    "8-bit op left a nonzero high byte")
  `CABF_ASSERT_NOW(a_no_strobe_unless_staged, out_valid, $past(in_vld_r),
    "strobe without a staged beat")

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for cpu_alu_and_bit_ops_flags_core
// Drives ALU beats through the command port (start/busy), predicts the value
// and flags of every accepted beat, and compares each strobed result in order.
// Directed corner beats first, then random traffic under three idling mixes,
// with a full drain between mixes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cabf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 235;
  localparam int unsigned TAIL_CYCLES  = 6;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  cabf_in_t  in_data = '0;
  logic      out_valid;
  cabf_out_t out_data;

  cabf_out_t   pending_alu_out[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  cpu_alu_and_bit_ops_flags_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Pack Z/N/H/C into the flag nibble
  function automatic logic [3:0] pack_flags(input logic z, input logic n,
                                            input logic h, input logic c);
    logic [3:0] f;
    f = '0;
    f[FLAG_Z] = z;
    f[FLAG_N] = n;
    f[FLAG_H] = h;
    f[FLAG_C] = c;
    return f;
  endfunction

  // Expected value and flags for one beat
  function automatic cabf_out_t predict_alu_result(input cabf_in_t x);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic        cin;
    logic        t;
    logic        sh_c;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [12:0] sum13;
    logic [16:0] sum17;
    cabf_out_t   y;
    a = x.operand_a[7:0];
    b = x.operand_b[7:0];
    cin = x.flags_in[FLAG_C];
    y.result = x.operand_a;
    y.flags_out = x.flags_in;
    r8 = '0;
    sh_c = 1'b0;
    case (x.opcode)
      OP_ADD, OP_ADC: begin
        t = (x.opcode == OP_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'd0, t};
        nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        y.result = {8'h00, sum9[7:0]};
        y.flags_out = pack_flags(sum9[7:0] == 8'h00, 1'b0, nib[4], sum9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // bit 8 / bit 4 of the wrapped difference is the borrow
        t = (x.opcode == OP_SBC) ? cin : 1'b0;
        sum9 = {1'b0, a} - {1'b0, b} - {8'd0, t};
        nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        if (x.opcode != OP_CP) begin
          y.result = {8'h00, sum9[7:0]};
        end
        y.flags_out = pack_flags(sum9[7:0] == 8'h00, 1'b1, nib[4], sum9[8]);
      end
      OP_AND: begin
        r8 = a & b;
        y.result = {8'h00, r8};
        y.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_XOR, OP_OR: begin
        r8 = (x.opcode == OP_XOR) ? (a ^ b) : (a | b);
        y.result = {8'h00, r8};
        y.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r8 = a + 8'd1;
        y.result = {8'h00, r8};
        y.flags_out = pack_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
      end
      OP_DEC: begin
        r8 = a - 8'd1;
        y.result = {8'h00, r8};
        y.flags_out = pack_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        case (x.opcode)
          OP_RLC:  begin r8 = {a[6:0], a[7]}; sh_c = a[7]; end
          OP_RRC:  begin r8 = {a[0], a[7:1]}; sh_c = a[0]; end
          OP_RL:   begin r8 = {a[6:0], cin};  sh_c = a[7]; end
          OP_RR:   begin r8 = {cin, a[7:1]};  sh_c = a[0]; end
          OP_SLA:  begin r8 = {a[6:0], 1'b0}; sh_c = a[7]; end
          OP_SRA:  begin r8 = {a[7], a[7:1]}; sh_c = a[0]; end
          OP_SWAP: begin r8 = {a[3:0], a[7:4]}; sh_c = 1'b0; end
          default: begin r8 = {1'b0, a[7:1]}; sh_c = a[0]; end
        endcase
        y.result = {8'h00, r8};
        y.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, sh_c);
      end
      OP_BIT: begin
        y.flags_out = pack_flags(~a[x.bit_index], 1'b0, 1'b1, cin);
      end
      OP_RES, OP_SET: begin
        r8 = a;
        r8[x.bit_index] = (x.opcode == OP_SET);
        y.result = {8'h00, r8};
      end
      OP_ADD16: begin
        sum17 = {1'b0, x.operand_a} + {1'b0, x.operand_b};
        sum13 = {1'b0, x.operand_a[11:0]} + {1'b0, x.operand_b[11:0]};
        y.result = sum17[15:0];
        y.flags_out = pack_flags(x.flags_in[FLAG_Z], 1'b0, sum13[12], sum17[16]);
      end
      default: begin
        // unused opcodes pass A and flags through
      end
    endcase
    return y;
  endfunction

  function automatic cabf_in_t mk_beat(input logic [4:0] op, input logic [15:0] a,
                                       input logic [15:0] b, input logic [2:0] idx,
                                       input logic [3:0] fl);
    cabf_in_t x;
    x.opcode = op;
    x.operand_a = a;
    x.operand_b = b;
    x.bit_index = idx;
    x.flags_in = fl;
    return x;
  endfunction

  // Operand biased toward flag corners in the low byte
  function automatic logic [15:0] rand_operand();
    logic [15:0] v;
    v = 16'($urandom_range(16'hFFFF, 0));
    if ($urandom_range(2, 0) == 0) begin
      case ($urandom_range(7, 0))
        0: v[7:0] = 8'h00;
        1: v[7:0] = 8'h01;
        2: v[7:0] = 8'h0F;
        3: v[7:0] = 8'h10;
        4: v[7:0] = 8'h7F;
        5: v[7:0] = 8'h80;
        6: v[7:0] = 8'hF0;
        default: v[7:0] = 8'hFF;
      endcase
    end
    return v;
  endfunction

  // Mostly defined opcodes, a few unused ones
  function automatic cabf_in_t rand_beat();
    logic [4:0] op;
    if ($urandom_range(9, 0) == 0) begin
      op = 5'($urandom_range(31, 22));
    end else begin
      op = 5'($urandom_range(21, 0));
    end
    return mk_beat(op, rand_operand(), rand_operand(), 3'($urandom_range(7, 0)),
                   4'($urandom_range(15, 0)));
  endfunction

  // Send one beat; called and returns at a falling edge, leaves start high
  task automatic send_beat(input cabf_in_t x, input int unsigned idle_pct);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= x;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    pending_alu_out.push_back(predict_alu_result(x));
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_alu_out.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic test_arith_edges();
    send_beat(mk_beat(OP_ADD, 16'hAAFF, 16'h5501, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_ADC, 16'h000F, 16'h0000, 3'd0, 4'h1), 0);
    send_beat(mk_beat(OP_SUB, 16'hFF00, 16'h0001, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_SBC, 16'h0010, 16'hFF0F, 3'd0, 4'h1), 0);
    send_beat(mk_beat(OP_CP,  16'hC33C, 16'h003C, 3'd0, 4'h0), 0);
  endtask

  task automatic test_logic_incdec();
    send_beat(mk_beat(OP_AND, 16'hFFFF, 16'hFF00, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_XOR, 16'h00A5, 16'h005A, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_OR,  16'hFF00, 16'h0F00, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_INC, 16'h12FF, 16'h0000, 3'd0, 4'h1), 0);
    send_beat(mk_beat(OP_DEC, 16'h0010, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_DEC, 16'h0001, 16'h0000, 3'd0, 4'h1), 0);
  endtask

  task automatic test_shift_rotate();
    send_beat(mk_beat(OP_RLC,  16'hFF80, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_RRC,  16'h0001, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_RL,   16'h0080, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_RR,   16'h0000, 16'h0000, 3'd0, 4'h1), 0);
    send_beat(mk_beat(OP_SLA,  16'h00FF, 16'h0000, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_SRA,  16'h0081, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_SWAP, 16'h00F0, 16'h0000, 3'd0, 4'hF), 0);
    send_beat(mk_beat(OP_SRL,  16'h0001, 16'h0000, 3'd0, 4'h0), 0);
  endtask

  task automatic test_bit_ops();
    send_beat(mk_beat(OP_BIT, 16'h0080, 16'h0000, 3'd7, 4'h1), 0);
    send_beat(mk_beat(OP_BIT, 16'hFFFE, 16'h0000, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_RES, 16'hFFFF, 16'h0000, 3'd7, 4'hA), 0);
    send_beat(mk_beat(OP_SET, 16'hFF00, 16'h0000, 3'd0, 4'h5), 0);
  endtask

  // Wide add carries, plus unused opcodes at both ends of the gap
  task automatic test_add16_and_unused();
    send_beat(mk_beat(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'h0), 0);
    send_beat(mk_beat(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'hF), 0);
    send_beat(mk_beat(5'd22, 16'h1234, 16'hFFFF, 3'd7, 4'hF), 0);
    send_beat(mk_beat(5'd31, 16'hFFFF, 16'h0000, 3'd0, 4'h6), 0);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct);
    repeat (RANDOM_BEATS) begin
      send_beat(rand_beat(), idle_pct);
    end
  endtask

  // Result check, oldest expectation first
  always @(posedge clk) begin : check_results
    cabf_out_t want;
    if (rst_n && out_valid) begin
      if (pending_alu_out.size() == 0) begin
        $error("unexpected result: result %h flags_out %h",
               out_data.result, out_data.flags_out);
        mismatch_count++;
      end else begin
        want = pending_alu_out.pop_front();
        if (out_data.result !== want.result) begin
          $error("result: expected %h, actual %h", want.result, out_data.result);
          mismatch_count++;
        end
        if (out_data.flags_out !== want.flags_out) begin
          $error("flags_out: expected %b, actual %b", want.flags_out,
                 out_data.flags_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_arith_edges();
    test_logic_incdec();
    test_shift_rotate();
    test_bit_ops();
    test_add16_and_unused();
    wait_drained();

    test_random_traffic(16);
    wait_drained();
    test_random_traffic(81);
    wait_drained();
    test_random_traffic(0);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_alu_out.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/cabf_pkg.sv
rtl/core/cabf_alu.sv
rtl/core/cpu_alu_and_bit_ops_flags_core.sv
tb/tb.sv
